[rtl/hwm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hwm_pkg: shared constants and types of the multilevel Haar transform
// Widths of the sample store, the fixed-point format and the store port bundles.
// ----------------------------------------------------------------------------
package hwm_pkg;

	localparam int MAX_LOG2 = 6;
	localparam int DEPTH    = 1 << MAX_LOG2;
	localparam int ADDR_W   = MAX_LOG2;
	localparam int CNT_W    = MAX_LOG2 + 1;
	localparam int SAMPLE_W = 16;
	localparam int FRAC_W   = MAX_LOG2;
	localparam int COEF_W   = SAMPLE_W + FRAC_W;
	localparam int LOG_W    = 3;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [COEF_W-1:0] data;
	} ram_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} ram_rd_t;

endpackage
`default_nettype wire

[rtl/hwm_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hwm_ram: sample store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module hwm_ram (
	input  wire logic                              clk,
	input  wire hwm_pkg::ram_wr_t                  wr,
	input  wire hwm_pkg::ram_rd_t                  rd,
	output logic signed [hwm_pkg::COEF_W-1:0]      rd_data
);

	logic [hwm_pkg::COEF_W-1:0] mem [hwm_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule
`default_nettype wire

[rtl/haar_wavelet_multilevel.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// haar_wavelet_multilevel: in-place multilevel Haar transform, averaging form
// Loads 2^L samples, runs L butterfly levels in the sample store, then emits
// the approximation and the detail coefficients, coarsest level first.
// ----------------------------------------------------------------------------
//  Channel   Signals                                   Handshake
//  ------    ----------------------------------------  -------------------------
//  input     sample                                    start & !busy
//  result    coefficient, level, last_of_block         valid, one cycle, no stall
//  config    cfg_wdata (length_log2)                   cfg_we
//
//  A sample is taken whenever start is high while the block fills. After the
//  last sample of a block, busy stays high through the butterfly and emit states;
//  every butterfly reads and writes the single store port pair twice. The last
//  coefficient is on the outputs in the first cycle with busy low. Reset clears
//  the fill count and sets length_log2 to 6; the store contents are not cleared.
// ----------------------------------------------------------------------------
module haar_wavelet_multilevel (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic signed [hwm_pkg::SAMPLE_W-1:0]   sample,
	input  wire logic                                  cfg_we,
	input  wire logic [hwm_pkg::LOG_W-1:0]             cfg_wdata,
	output logic                                       valid,
	output logic signed [hwm_pkg::COEF_W-1:0]          coefficient,
	output logic [hwm_pkg::LOG_W-1:0]                  level,
	output logic                                       last_of_block
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_A,
		ST_RD_B,
		ST_WR_A,
		ST_WR_B,
		ST_EMIT
	} state_t;

	state_t                          state_q;
	logic [hwm_pkg::LOG_W-1:0]       length_q;
	logic [hwm_pkg::CNT_W-1:0]       load_count_q;
	logic [hwm_pkg::CNT_W-1:0]       bf_i_q;
	logic [hwm_pkg::LOG_W-1:0]       bf_sh_q;
	logic [hwm_pkg::CNT_W-1:0]       em_i_q;
	logic [hwm_pkg::LOG_W-1:0]       em_sh_q;
	logic                            em_first_q;
	logic signed [hwm_pkg::COEF_W-1:0] a_q;
	logic [hwm_pkg::COEF_W-1:0]      diff_q;
	logic                            valid_s1;
	logic [hwm_pkg::LOG_W-1:0]       level_s1;
	logic                            last_s1;

	logic [hwm_pkg::LOG_W-1:0]       lg;
	logic [hwm_pkg::CNT_W-1:0]       n;
	logic [hwm_pkg::CNT_W-1:0]       bf_stride;
	logic [hwm_pkg::CNT_W-1:0]       bf_next_i;
	logic [hwm_pkg::CNT_W-1:0]       bf_b_idx;
	logic [hwm_pkg::CNT_W-1:0]       em_next_i;
	logic [hwm_pkg::COEF_W:0]        sum_w;
	logic [hwm_pkg::COEF_W:0]        dif_w;
	logic signed [hwm_pkg::COEF_W-1:0] rd_data;
	hwm_pkg::ram_wr_t                wr;
	hwm_pkg::ram_rd_t                rd;

	// Out-of-range lengths saturate to the supported span.
	always_comb begin
		priority if (length_q == '0) begin
			lg = hwm_pkg::LOG_W'(1);
		end else if (length_q > hwm_pkg::LOG_W'(hwm_pkg::MAX_LOG2)) begin
			lg = hwm_pkg::LOG_W'(hwm_pkg::MAX_LOG2);
		end else begin
			lg = length_q;
		end
	end

	assign n         = hwm_pkg::CNT_W'(1) << lg;
	assign bf_stride = hwm_pkg::CNT_W'(1) << bf_sh_q;
	assign bf_next_i = bf_i_q + (bf_stride << 1);
	assign bf_b_idx  = bf_i_q + bf_stride;
	assign em_next_i = em_i_q + (hwm_pkg::CNT_W'(2) << em_sh_q);

	// Halving with an arithmetic shift is floor division by two.
	assign sum_w = {a_q[hwm_pkg::COEF_W-1], a_q} + {rd_data[hwm_pkg::COEF_W-1], rd_data};
	assign dif_w = {a_q[hwm_pkg::COEF_W-1], a_q} - {rd_data[hwm_pkg::COEF_W-1], rd_data};

	always_comb begin
		wr = '0;
		rd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					wr.we   = 1'b1;
					wr.addr = load_count_q[hwm_pkg::ADDR_W-1:0];
					wr.data = {sample, {hwm_pkg::FRAC_W{1'b0}}};
				end
			end
			ST_RD_A: begin
				rd.en   = 1'b1;
				rd.addr = bf_i_q[hwm_pkg::ADDR_W-1:0];
			end
			ST_RD_B: begin
				rd.en   = 1'b1;
				rd.addr = bf_b_idx[hwm_pkg::ADDR_W-1:0];
			end
			ST_WR_A: begin
				wr.we   = 1'b1;
				wr.addr = bf_i_q[hwm_pkg::ADDR_W-1:0];
				wr.data = sum_w[hwm_pkg::COEF_W:1];
			end
			ST_WR_B: begin
				wr.we   = 1'b1;
				wr.addr = bf_b_idx[hwm_pkg::ADDR_W-1:0];
				wr.data = diff_q;
			end
			ST_EMIT: begin
				rd.en   = 1'b1;
				rd.addr = em_first_q ? '0 : em_i_q[hwm_pkg::ADDR_W-1:0];
			end
			default: begin
				wr = '0;
				rd = '0;
			end
		endcase
	end

	hwm_ram u_ram (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			length_q     <= hwm_pkg::LOG_W'(hwm_pkg::MAX_LOG2);
			load_count_q <= '0;
			bf_i_q       <= '0;
			bf_sh_q      <= '0;
			em_i_q       <= '0;
			em_sh_q      <= '0;
			em_first_q   <= 1'b0;
			a_q          <= '0;
			diff_q       <= '0;
			valid_s1     <= 1'b0;
			level_s1     <= '0;
			last_s1      <= 1'b0;
		end else begin
			valid_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_we) begin
						length_q     <= cfg_wdata;
						load_count_q <= '0;
					end else if (start) begin
						if (load_count_q + hwm_pkg::CNT_W'(1) == n) begin
							load_count_q <= '0;
							bf_i_q       <= '0;
							bf_sh_q      <= '0;
							state_q      <= ST_RD_A;
						end else begin
							load_count_q <= load_count_q + hwm_pkg::CNT_W'(1);
						end
					end
				end
				ST_RD_A: begin
					state_q <= ST_RD_B;
				end
				ST_RD_B: begin
					a_q     <= rd_data;
					state_q <= ST_WR_A;
				end
				ST_WR_A: begin
					diff_q  <= dif_w[hwm_pkg::COEF_W:1];
					state_q <= ST_WR_B;
				end
				ST_WR_B: begin
					if (bf_next_i < n) begin
						bf_i_q  <= bf_next_i;
						state_q <= ST_RD_A;
					end else if (bf_sh_q + hwm_pkg::LOG_W'(1) == lg) begin
						em_first_q <= 1'b1;
						em_sh_q    <= lg - hwm_pkg::LOG_W'(1);
						em_i_q     <= hwm_pkg::CNT_W'(1) << (lg - hwm_pkg::LOG_W'(1));
						state_q    <= ST_EMIT;
					end else begin
						bf_i_q  <= '0;
						bf_sh_q <= bf_sh_q + hwm_pkg::LOG_W'(1);
						state_q <= ST_RD_A;
					end
				end
				ST_EMIT: begin
					valid_s1 <= 1'b1;
					if (em_first_q) begin
						em_first_q <= 1'b0;
						level_s1   <= '0;
						last_s1    <= 1'b0;
					end else begin
						level_s1 <= lg - em_sh_q;
						last_s1  <= (em_sh_q == '0) && (em_i_q == n - hwm_pkg::CNT_W'(1));
						// Walk the odd multiples of each stride, coarsest stride first.
						if (em_next_i < n) begin
							em_i_q <= em_next_i;
						end else if (em_sh_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							em_sh_q <= em_sh_q - hwm_pkg::LOG_W'(1);
							em_i_q  <= hwm_pkg::CNT_W'(1) << (em_sh_q - hwm_pkg::LOG_W'(1));
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign valid         = valid_s1;
	assign coefficient   = rd_data;
	assign level         = level_s1;
	assign last_of_block = last_s1;

	// A coefficient only leaves the block in the cycle after an emit read.
	a_valid_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(state_q == ST_EMIT))
		else $error("result strobe without a preceding emit read");

	// The fill count never reaches the block length.
	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		load_count_q < n)
		else $error("fill count reached the block length");

	// The store never reads and writes one entry in the same cycle.
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr.we && rd.en && (wr.addr == rd.addr)))
		else $error("store read and write collide on one entry");

	// The final coefficient closes the emit pass.
	a_last_ends_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && last_of_block) |-> (state_q == ST_IDLE))
		else $error("last coefficient while still transforming");

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the multilevel Haar transform
// Loads blocks of samples at every block length, predicts the coefficients of
// each block in the bench and compares every emitted coefficient, level and
// end-of-block flag in order. A short table of directed items comes first,
// then random blocks under varying sender gaps.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int STALL_LIMIT  = 4000;
	localparam int SETTLE_TICKS = 8;
	localparam int REPORT_MAX   = 10;
	localparam int DIR_ROWS     = 30;
	localparam int APPROX_LEVEL = 0;
	localparam int PART_MAX     = 4;

	typedef enum logic { ROW_CFG, ROW_SAMPLE } row_op_t;

	typedef struct {
		row_op_t op;
		int      value;
		bit      typed;
		int      t_approx;
		int      t_detail;
	} dir_row_t;

	typedef struct packed {
		logic signed [hwm_pkg::COEF_W-1:0] coef;
		logic [hwm_pkg::LOG_W-1:0]         lvl;
		logic                              last;
	} coef_t;

	logic                                clk;
	logic                                arst_n;
	logic                                start;
	logic                                busy;
	logic signed [hwm_pkg::SAMPLE_W-1:0] sample;
	logic                                cfg_we;
	logic [hwm_pkg::LOG_W-1:0]           cfg_wdata;
	logic                                valid;
	logic signed [hwm_pkg::COEF_W-1:0]   coefficient;
	logic [hwm_pkg::LOG_W-1:0]           level;
	logic                                last_of_block;

	// Bench copy of the block state.
	longint                    haar_store [hwm_pkg::DEPTH];
	int                        fill_count;
	logic [hwm_pkg::LOG_W-1:0] length_reg;

	coef_t    coef_expected [$];
	coef_t    want;
	dir_row_t dir_rows [DIR_ROWS];
	int       mismatches;
	int       stall_cycles;
	int       gap_pct;

	haar_wavelet_multilevel dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.sample        (sample),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.valid         (valid),
		.coefficient   (coefficient),
		.level         (level),
		.last_of_block (last_of_block)
	);

	always #2 clk = ~clk;

	function automatic int block_size(input logic [hwm_pkg::LOG_W-1:0] v);
		if (v < 1)
			return 2;
		if (v > hwm_pkg::MAX_LOG2)
			return 1 << hwm_pkg::MAX_LOG2;
		return 1 << v;
	endfunction

	function automatic logic signed [hwm_pkg::SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(7))
			0: return -32768;
			1: return 32767;
			2: return -1;
			3: return 0;
			default: return hwm_pkg::SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic expect_coef(input longint v, input int lvl, input bit last);
		coef_t r;
		r.coef = hwm_pkg::COEF_W'(v);
		r.lvl  = hwm_pkg::LOG_W'(lvl);
		r.last = last;
		coef_expected.push_back(r);
	endtask

	// Stores one sample; on the last sample of a block, runs every butterfly
	// level in place and, if queue_results is set, queues the coefficients in emit order.
	task automatic haar_take_sample(input logic signed [hwm_pkg::SAMPLE_W-1:0] s,
			input bit queue_results);
		int     n;
		int     k;
		int     i;
		int     lvl;
		int     cnt;
		longint a;
		longint b;
		n = block_size(length_reg);
		if (fill_count >= n)
			fill_count = 0;
		haar_store[fill_count] = longint'(s) * (1 << hwm_pkg::FRAC_W);
		fill_count++;
		if (fill_count < n)
			return;
		fill_count = 0;
		for (k = 1; k < n; k *= 2) begin
			for (i = 0; i + k < n; i += 2 * k) begin
				a = haar_store[i];
				b = haar_store[i + k];
				haar_store[i]     = (a + b) >>> 1;
				haar_store[i + k] = (a - b) >>> 1;
			end
		end
		if (!queue_results)
			return;
		expect_coef(haar_store[0], APPROX_LEVEL, n == 1);
		cnt = 1;
		lvl = 1;
		for (k = n / 2; k >= 1; k /= 2) begin
			for (i = k; i < n; i += 2 * k) begin
				expect_coef(haar_store[i], lvl, cnt + 1 == n);
				cnt++;
			end
			lvl++;
		end
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance
	// with start still high, so back-to-back items keep it asserted.
	task automatic drive_sample(input logic signed [hwm_pkg::SAMPLE_W-1:0] s,
			input bit typed, input int t_approx, input int t_detail);
		while ($urandom_range(99) < gap_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start  = 1'b1;
		sample = s;
		do
			@(posedge clk);
		while (busy);
		haar_take_sample(s, !typed);
		if (typed) begin
			expect_coef(t_approx, APPROX_LEVEL, 1'b0);
			expect_coef(t_detail, 1, 1'b1);
		end
		@(negedge clk);
	endtask

	// Holds the sender off until every queued coefficient has come, then lets
	// the block settle after any load that produced nothing.
	task automatic wait_drained();
		start = 1'b0;
		while (coef_expected.size() != 0)
			@(negedge clk);
		repeat (SETTLE_TICKS) @(negedge clk);
	endtask

	task automatic write_length(input logic [hwm_pkg::LOG_W-1:0] v);
		wait_drained();
		cfg_we    = 1'b1;
		cfg_wdata = v;
		@(posedge clk);
		length_reg = v;
		fill_count = 0;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && valid) begin
			if (coef_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected coefficient %0d level %0d last %0b",
						coefficient, level, last_of_block);
			end else begin
				want = coef_expected.pop_front();
				if (coefficient !== want.coef || level !== want.lvl ||
						last_of_block !== want.last) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("coefficient exp %0d/%0d/%0b got %0d/%0d/%0b",
							want.coef, want.lvl, want.last,
							coefficient, level, last_of_block);
				end
			end
		end
	end

	// Watchdog: any cycle that moves an item, a coefficient or a register
	// write counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || valid || cfg_we) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("haar_wavelet_multilevel: mismatch");
				$finish;
			end
		end
	end

	initial begin
		int settings [7];
		int si;
		int b;
		int j;
		int n;
		int blocks;
		int part;
		clk          = 1'b0;
		arst_n       = 1'b0;
		start        = 1'b0;
		sample       = '0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		mismatches   = 0;
		stall_cycles = 0;
		gap_pct      = 31;
		fill_count   = 0;
		length_reg   = 3'd6;
		settings     = '{7, 4, 1, 5, 2, 3, 0};

		// A few loads at the reset length must stay silent and are dropped by
		// the first length write. Two-sample blocks at the extremes of the
		// sample range have coefficients that can be read off directly.
		dir_rows = '{
			'{ROW_SAMPLE, 100, 0, 0, 0},
			'{ROW_SAMPLE, -5, 0, 0, 0},
			'{ROW_SAMPLE, 9, 0, 0, 0},
			'{ROW_CFG, 1, 0, 0, 0},
			'{ROW_SAMPLE, 32767, 0, 0, 0},
			'{ROW_SAMPLE, 32767, 1, 2097088, 0},
			'{ROW_SAMPLE, -32768, 0, 0, 0},
			'{ROW_SAMPLE, -32768, 1, -2097152, 0},
			'{ROW_SAMPLE, 32767, 0, 0, 0},
			'{ROW_SAMPLE, -32768, 1, -32, 2097120},
			'{ROW_SAMPLE, -32768, 0, 0, 0},
			'{ROW_SAMPLE, 32767, 1, -32, -2097120},
			'{ROW_SAMPLE, 3, 0, 0, 0},
			'{ROW_CFG, 0, 0, 0, 0},
			'{ROW_SAMPLE, 1, 0, 0, 0},
			'{ROW_SAMPLE, -2, 1, -32, 96},
			'{ROW_CFG, 2, 0, 0, 0},
			'{ROW_SAMPLE, 1, 0, 0, 0},
			'{ROW_SAMPLE, 2, 0, 0, 0},
			'{ROW_SAMPLE, 3, 0, 0, 0},
			'{ROW_SAMPLE, 4, 0, 0, 0},
			'{ROW_CFG, 3, 0, 0, 0},
			'{ROW_SAMPLE, -32768, 0, 0, 0},
			'{ROW_SAMPLE, 32767, 0, 0, 0},
			'{ROW_SAMPLE, -1, 0, 0, 0},
			'{ROW_SAMPLE, 0, 0, 0, 0},
			'{ROW_SAMPLE, 1, 0, 0, 0},
			'{ROW_SAMPLE, 21845, 0, 0, 0},
			'{ROW_SAMPLE, -21846, 0, 0, 0},
			'{ROW_SAMPLE, 100, 0, 0, 0}
		};

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (j = 0; j < DIR_ROWS; j++) begin
			if (dir_rows[j].op == ROW_CFG)
				write_length(hwm_pkg::LOG_W'(dir_rows[j].value));
			else
				drive_sample(hwm_pkg::SAMPLE_W'(dir_rows[j].value), dir_rows[j].typed,
					dir_rows[j].t_approx, dir_rows[j].t_detail);
		end

		for (si = 0; si < 7; si++) begin
			gap_pct = (si < 2) ? 31 : (si < 5) ? 56 : 0;
			write_length(hwm_pkg::LOG_W'(settings[si]));
			n      = block_size(hwm_pkg::LOG_W'(settings[si]));
			blocks = (n == 2) ? 2 : 1;
			for (b = 0; b < blocks; b++) begin
				if (b == 1 && si == 2)
					wait_drained();
				for (j = 0; j < n; j++)
					drive_sample(pick_sample(), 1'b0, 0, 0);
			end
			// Sometimes leave a partial block for the next length write to drop.
			if ($urandom_range(1)) begin
				part = $urandom_range(1, (n > PART_MAX) ? PART_MAX : n - 1);
				for (j = 0; j < part; j++)
					drive_sample(pick_sample(), 1'b0, 0, 0);
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && coef_expected.size() == 0)
			$display("haar_wavelet_multilevel: match");
		else
			$display("haar_wavelet_multilevel: mismatch");
		$finish;
	end

endmodule

[sim.f]
rtl/hwm_pkg.sv
rtl/hwm_ram.sv
rtl/haar_wavelet_multilevel.sv
tb/tb_top.sv
